// ===== hw/rtl/srrr_pkg.sv =====
// ----------------------------------------------------------------------------
// srrr_pkg: shared types and constants of the reorder receiver
// Window geometry, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package srrr_pkg;

	localparam int WINDOW      = 32;
	localparam int SEQ_W       = $clog2(WINDOW);
	localparam int MAX_PAYLOAD = 1464;

	localparam int FRM_W  = 5;
	localparam int LEN_W  = 11;
	localparam int HDL_W  = 32;
	localparam int DATA_W = FRM_W + LEN_W + HDL_W;  // 48, whole bytes
	localparam int USER_W = 2;

	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the incoming frame
		logic ack_load;  // emit acknowledge, store frame if not behind, record end mark
		logic dlv_rd;    // first read of the slot at the expected number
		logic dlv_load;  // emit delivery, clear slot, advance expected number
	} srrr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_equal;     // captured frame equals expected number
		logic out_free;     // output register can take a result this cycle
		logic next_filled;  // slot after the expected number is filled
	} srrr_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/selective_repeat_reorder_receiver_core.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver_core: selective-repeat receive window
// Acknowledges every frame, buffers out-of-order frames by handle and
// delivers them in sequence once the expected frame arrives.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | contents
//  s_*      | in  | tvalid / tready  | frame number, length, handle; tlast = end mark
//  m_*      | out | tvalid / tready  | ack or delivery; tuser = kind, finished;
//           |     |                  | tlast = last result of the frame
//
//  A frame passes capture, then acknowledge; one that completes a run adds a
//  slot read and then one delivery per frame, paced by the single read port
//  of the slot store. s_tready is high only between frames.
//  Reset clears the expected number, the end record and all slot valid bits
//  at once; no clearing pass is needed. A stalled m_tready holds the
//  sequencer in place; a waiting result does not block the next capture.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_reorder_receiver_core
	import srrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // frame_num, payload_len, payload_handle
	input  wire logic              s_tlast,   // end_mark
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // out_frame, out_len, out_handle
	output logic [USER_W-1:0]      m_tuser,   // kind, finished
	output logic                   m_tlast    // last_of_run
);

	srrr_cmd_t        cmd;
	srrr_sts_t        sts;
	logic             kind;
	logic [FRM_W-1:0] frame;
	logic [LEN_W-1:0] len;
	logic [HDL_W-1:0] handle;
	logic             fin;

	srrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srrr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_frame   (s_tdata[FRM_W-1:0]),
		.in_mark    (s_tlast),
		.in_len     (s_tdata[FRM_W+LEN_W-1:FRM_W]),
		.in_handle  (s_tdata[DATA_W-1:FRM_W+LEN_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (kind),
		.out_frame  (frame),
		.out_len    (len),
		.out_handle (handle),
		.out_fin    (fin),
		.out_last   (m_tlast)
	);

	assign m_tdata = {handle, len, frame};
	assign m_tuser = {fin, kind};

endmodule

`default_nettype wire

// ===== hw/rtl/srrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// srrr_ctrl: sequencer of the reorder receiver
// Accepts a frame, issues its acknowledge, then walks the in-order drain.
// ----------------------------------------------------------------------------
`default_nettype none

module srrr_ctrl
	import srrr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire srrr_sts_t sts,
	output srrr_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_RD,
		ST_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.ack_load = (state_q == ST_ACK) && sts.out_free;
		cmd.dlv_rd   = (state_q == ST_RD);
		cmd.dlv_load = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (sts.out_free)
						state_q <= sts.is_equal ? ST_RD : ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free && !sts.next_filled)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srrr_dp.sv =====
// ----------------------------------------------------------------------------
// srrr_dp: datapath of the reorder receiver
// Frame capture, window compare, slot store with valid bits, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srrr_dp
	import srrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srrr_cmd_t         cmd,
	output srrr_sts_t              sts,
	input  wire logic [FRM_W-1:0]  in_frame,
	input  wire logic              in_mark,
	input  wire logic [LEN_W-1:0]  in_len,
	input  wire logic [HDL_W-1:0]  in_handle,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_kind,
	output logic [FRM_W-1:0]       out_frame,
	output logic [LEN_W-1:0]       out_len,
	output logic [HDL_W-1:0]       out_handle,
	output logic                   out_fin,
	output logic                   out_last
);

	localparam logic [SEQ_W:0] SEQ_HALF = (SEQ_W+1)'(WINDOW / 2);

	// captured frame
	logic [FRM_W-1:0] frm_q;
	logic             mark_q;
	logic [LEN_W-1:0] len_q;
	logic [HDL_W-1:0] hdl_q;

	// window state
	logic [SEQ_W-1:0]  exp_q;
	logic              end_vld_q;
	logic [SEQ_W-1:0]  end_frm_q;
	logic [WINDOW-1:0] filled_q;

	// slot store: {handle, length}
	logic [LEN_W+HDL_W-1:0] mem [WINDOW];
	logic [LEN_W+HDL_W-1:0] rd_q;

	// output register
	logic             vld_q;
	logic             kind_q;
	logic [FRM_W-1:0] ofrm_q;
	logic [LEN_W-1:0] olen_q;
	logic [HDL_W-1:0] ohdl_q;
	logic             fin_q;
	logic             last_q;

	logic [SEQ_W-1:0] f;
	logic [SEQ_W-1:0] exp_nxt;
	logic [SEQ_W-1:0] rd_addr;
	logic [SEQ_W-1:0] back_dist;
	logic             is_ahead;
	logic             is_equal;
	logic             out_free;
	logic             do_store;

	assign f         = frm_q[SEQ_W-1:0];
	assign exp_nxt   = exp_q + SEQ_W'(1);
	assign back_dist = exp_q - f;
	// ahead: numerically above, or so far below that it must have wrapped
	assign is_ahead  = (f > exp_q) || ((f < exp_q) && ({1'b0, back_dist} > SEQ_HALF));
	assign is_equal  = (f == exp_q);
	assign out_free  = !vld_q || out_ready;
	assign do_store  = cmd.ack_load && (is_ahead || is_equal);
	assign rd_addr   = cmd.dlv_load ? exp_nxt : exp_q;

	always_comb begin
		sts.is_equal    = is_equal;
		sts.out_free    = out_free;
		sts.next_filled = filled_q[exp_nxt];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frm_q  <= in_frame;
			mark_q <= in_mark;
			len_q  <= (in_len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len;
			hdl_q  <= in_handle;
		end
	end

	always_ff @(posedge clk) begin
		if (do_store)
			mem[f] <= {hdl_q, len_q};
		if (cmd.dlv_rd || cmd.dlv_load)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= '0;
			end_vld_q <= 1'b0;
			end_frm_q <= '0;
			filled_q  <= '0;
		end else begin
			if (cmd.ack_load && mark_q) begin
				end_vld_q <= 1'b1;
				end_frm_q <= f;
			end
			if (do_store)
				filled_q[f] <= 1'b1;
			if (cmd.dlv_load) begin
				filled_q[exp_q] <= 1'b0;
				exp_q           <= exp_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.ack_load || cmd.dlv_load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack_load) begin
			kind_q <= KIND_ACK;
			ofrm_q <= frm_q;
			olen_q <= '0;
			ohdl_q <= '0;
			fin_q  <= 1'b0;
			last_q <= !is_equal;
		end else if (cmd.dlv_load) begin
			kind_q <= KIND_DELIVER;
			ofrm_q <= FRM_W'(exp_q);
			olen_q <= rd_q[LEN_W-1:0];
			ohdl_q <= rd_q[LEN_W+HDL_W-1:LEN_W];
			fin_q  <= end_vld_q && (exp_q == end_frm_q);
			last_q <= !filled_q[exp_nxt];
		end
	end

	assign out_valid  = vld_q;
	assign out_kind   = kind_q;
	assign out_frame  = ofrm_q;
	assign out_len    = olen_q;
	assign out_handle = ohdl_q;
	assign out_fin    = fin_q;
	assign out_last   = last_q;

	a_dlv_from_filled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dlv_load |-> filled_q[exp_q])
		else $error("delivery from an empty slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ack_load || cmd.dlv_load) |-> out_free)
		else $error("output register overwritten while held");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ack_load && cmd.dlv_load))
		else $error("acknowledge and delivery in the same cycle");

	a_store_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_store |=> filled_q[$past(f)])
		else $error("stored slot not marked filled");

endmodule

`default_nettype wire
